[sv/fcr_pkg.sv]
// Shared types, constants and the checksum step for the frame check and reply engine.
`default_nettype none

package fcr_pkg;

   localparam int COUNTER_WIDTH = 32;

   localparam int FRAME_BYTES = 20;
   localparam int SUM_BYTES   = 16;
   localparam int POS_WIDTH   = 5;

   localparam logic [31:0] SUM_SEED      = 32'h1357_2468;
   localparam logic [7:0]  MAGIC_LO      = 8'h5A;
   localparam logic [7:0]  MAGIC_HI      = 8'hA5;
   localparam logic [7:0]  EXPECTED_ROLE = 8'h01;
   localparam logic [7:0]  LENGTH_MAX    = 8'hFF;

   localparam logic [POS_WIDTH-1:0] POS_ROLE     = 5'd2;
   localparam logic [POS_WIDTH-1:0] POS_SUM0     = 5'd16;
   localparam logic [POS_WIDTH-1:0] POS_LAST     = 5'd19;
   localparam logic [POS_WIDTH-1:0] POS_COMPLETE = 5'd20;

   localparam logic [1:0] REQ_BYTE = 2'd0;
   localparam logic [1:0] REQ_STOP = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;
   localparam logic [1:0] REQ_NONE = 2'd3;

   localparam logic [1:0] CSR_NODE_ROLE     = 2'd0;
   localparam logic [1:0] CSR_SESSION_NONCE = 2'd1;
   localparam logic [1:0] CSR_TRACE_ENABLE  = 2'd2;

   localparam logic RESULT_VERDICT = 1'b0;
   localparam logic RESULT_REPLY   = 1'b1;

   localparam logic [6:0]  NODE_ROLE_RESET = 7'd12;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  out_byte;
      logic        last;
      logic        frame_valid;
      logic [31:0] valid_total;
      logic [31:0] invalid_total;
      logic [7:0]  received_length;
   } rsp_payload_type;

   typedef enum logic {
      CMD_VERDICT = 1'b0,
      CMD_REPLY   = 1'b1
   } cmd_kind_type;

   // One unit of work for the back end: a verdict or a reply frame snapshot.
   typedef struct packed {
      cmd_kind_type             kind;
      logic                     frame_valid;
      logic [COUNTER_WIDTH-1:0] valid_total;
      logic [COUNTER_WIDTH-1:0] invalid_total;
      logic [7:0]               received_length;
      logic [6:0]               node_role;
      logic                     trace_enable;
      logic [31:0]              session_nonce;
      logic [COUNTER_WIDTH-1:0] prepared_total;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

   function automatic logic [31:0] sum_step(input logic [31:0] sum, input logic [7:0] b);
      logic [31:0] rot;
      rot = {sum[26:0], sum[31:27]};
      return rot ^ {24'd0, b};
   endfunction

endpackage

`default_nettype wire

[sv/fcr_queue.sv]
// Two-entry command queue between the receive front end and the reply back end.
`default_nettype none

module fcr_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire fcr_pkg::cmd_type            push_cmd,
   input  wire logic                        pop,
   output fcr_pkg::cmd_type                 head_cmd,
   output fcr_pkg::queue_status_type        status
);

   fcr_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = entry_ff[rd_ptr_ff];
   assign status   = '{full: count_ff[1], head_valid: (count_ff != 2'd0)};

endmodule

`default_nettype wire

[sv/fcr_front.sv]
// Front end: accepts requests, checks received frames, keeps counters and registers.
`default_nettype none

module fcr_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire fcr_pkg::req_payload_type req_payload,
   input  wire logic                     csr_write_enable,
   input  wire logic [1:0]               csr_index,
   input  wire logic [31:0]              csr_write_data,
   input  wire fcr_pkg::queue_status_type queue_status,
   output logic                          push,
   output fcr_pkg::cmd_type              push_cmd
);

   localparam int CW = fcr_pkg::COUNTER_WIDTH;

   logic [6:0]  node_role_ff;
   logic [31:0] session_nonce_ff;
   logic        trace_enable_ff;

   logic [fcr_pkg::POS_WIDTH-1:0] byte_position_ff, byte_position_in;
   logic [31:0]   running_sum_ff, running_sum_in;
   logic          header_good_ff, header_good_in;
   logic [31:0]   received_sum_ff, received_sum_in;
   logic [7:0]    write_length_ff, write_length_in;
   logic [CW-1:0] valid_count_ff, valid_count_in;
   logic [CW-1:0] invalid_count_ff, invalid_count_in;
   logic [CW-1:0] prepared_count_ff, prepared_count_in;

   logic accept;
   logic frame_ok;
   logic [7:0] b;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;
   assign b         = req_payload.data_byte;
   assign frame_ok  = (byte_position_ff == fcr_pkg::POS_COMPLETE) && header_good_ff &&
                      (running_sum_ff == received_sum_ff);

   always_comb begin
      byte_position_in  = byte_position_ff;
      running_sum_in    = running_sum_ff;
      header_good_in    = header_good_ff;
      received_sum_in   = received_sum_ff;
      write_length_in   = write_length_ff;
      valid_count_in    = valid_count_ff;
      invalid_count_in  = invalid_count_ff;
      prepared_count_in = prepared_count_ff;
      push              = 1'b0;

      push_cmd                 = '0;
      push_cmd.kind            = fcr_pkg::CMD_VERDICT;
      push_cmd.node_role       = node_role_ff;
      push_cmd.trace_enable    = trace_enable_ff;
      push_cmd.session_nonce   = session_nonce_ff;
      push_cmd.prepared_total  = prepared_count_ff;
      push_cmd.valid_total     = valid_count_ff;
      push_cmd.invalid_total   = invalid_count_ff;
      push_cmd.received_length = write_length_ff;
      push_cmd.frame_valid     = frame_ok;

      if (accept) begin
         unique case (req_payload.req_type)
            fcr_pkg::REQ_BYTE: begin
               if (byte_position_ff < fcr_pkg::POS_COMPLETE) begin
                  if ((byte_position_ff == 5'd0) && (b != fcr_pkg::MAGIC_LO)) begin
                     header_good_in = 1'b0;
                  end
                  if ((byte_position_ff == 5'd1) && (b != fcr_pkg::MAGIC_HI)) begin
                     header_good_in = 1'b0;
                  end
                  if ((byte_position_ff == fcr_pkg::POS_ROLE) &&
                      (b != fcr_pkg::EXPECTED_ROLE)) begin
                     header_good_in = 1'b0;
                  end
                  if (byte_position_ff < fcr_pkg::POS_SUM0) begin
                     running_sum_in = fcr_pkg::sum_step(running_sum_ff, b);
                  end else begin
                     unique case (byte_position_ff[1:0])
                        2'd0: received_sum_in[7:0]   = received_sum_ff[7:0]   | b;
                        2'd1: received_sum_in[15:8]  = received_sum_ff[15:8]  | b;
                        2'd2: received_sum_in[23:16] = received_sum_ff[23:16] | b;
                        default: received_sum_in[31:24] = received_sum_ff[31:24] | b;
                     endcase
                  end
                  byte_position_in = byte_position_ff + 5'd1;
               end
               if (write_length_ff != fcr_pkg::LENGTH_MAX) begin
                  write_length_in = write_length_ff + 8'd1;
               end
            end
            fcr_pkg::REQ_STOP: begin
               if (frame_ok) begin
                  valid_count_in = valid_count_ff + CW'(1);
               end else begin
                  invalid_count_in = invalid_count_ff + CW'(1);
               end
               prepared_count_in      = prepared_count_ff + CW'(1);
               push                   = 1'b1;
               push_cmd.valid_total   = valid_count_in;
               push_cmd.invalid_total = invalid_count_in;
               byte_position_in       = '0;
               running_sum_in         = fcr_pkg::SUM_SEED;
               header_good_in         = 1'b1;
               received_sum_in        = '0;
               write_length_in        = '0;
            end
            fcr_pkg::REQ_READ: begin
               push          = 1'b1;
               push_cmd.kind = fcr_pkg::CMD_REPLY;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         running_sum_ff    <= fcr_pkg::SUM_SEED;
         header_good_ff    <= 1'b1;
         received_sum_ff   <= '0;
         write_length_ff   <= '0;
         valid_count_ff    <= '0;
         invalid_count_ff  <= '0;
         prepared_count_ff <= CW'(1);
      end else begin
         byte_position_ff  <= byte_position_in;
         running_sum_ff    <= running_sum_in;
         header_good_ff    <= header_good_in;
         received_sum_ff   <= received_sum_in;
         write_length_ff   <= write_length_in;
         valid_count_ff    <= valid_count_in;
         invalid_count_ff  <= invalid_count_in;
         prepared_count_ff <= prepared_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_role_ff     <= fcr_pkg::NODE_ROLE_RESET;
         session_nonce_ff <= '0;
         trace_enable_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fcr_pkg::CSR_NODE_ROLE:     node_role_ff     <= csr_write_data[6:0];
            fcr_pkg::CSR_SESSION_NONCE: session_nonce_ff <= csr_write_data;
            fcr_pkg::CSR_TRACE_ENABLE:  trace_enable_ff  <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[sv/fcr_back.sv]
// Back end: turns queued commands into verdicts or 20-byte reply frames, one byte a cycle while rsp_stall is low.
`default_nettype none

module fcr_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fcr_pkg::queue_status_type queue_status,
   input  wire fcr_pkg::cmd_type          head_cmd,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output fcr_pkg::rsp_payload_type       rsp_payload
);

   logic [fcr_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [31:0] sum_ff, sum_in;
   logic        rsp_valid_ff, rsp_valid_in;
   fcr_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        load;
   logic        at_last;
   logic [7:0]  frame_byte;
   logic [31:0] prepared32;
   logic [31:0] valid32;

   assign load       = queue_status.head_valid && (!rsp_valid_ff || !rsp_stall);
   assign at_last    = (pos_ff == fcr_pkg::POS_LAST);
   assign prepared32 = 32'(head_cmd.prepared_total);
   assign valid32    = 32'(head_cmd.valid_total);

   always_comb begin
      unique case (pos_ff)
         5'd0:  frame_byte = fcr_pkg::MAGIC_LO;
         5'd1:  frame_byte = fcr_pkg::MAGIC_HI;
         5'd2:  frame_byte = {1'b0, head_cmd.node_role};
         5'd3:  frame_byte = {7'd0, head_cmd.trace_enable};
         5'd4:  frame_byte = head_cmd.session_nonce[7:0];
         5'd5:  frame_byte = head_cmd.session_nonce[15:8];
         5'd6:  frame_byte = head_cmd.session_nonce[23:16];
         5'd7:  frame_byte = head_cmd.session_nonce[31:24];
         5'd8:  frame_byte = prepared32[7:0];
         5'd9:  frame_byte = prepared32[15:8];
         5'd10: frame_byte = prepared32[23:16];
         5'd11: frame_byte = prepared32[31:24];
         5'd12: frame_byte = valid32[7:0];
         5'd13: frame_byte = valid32[15:8];
         5'd14: frame_byte = valid32[23:16];
         5'd15: frame_byte = valid32[31:24];
         5'd16: frame_byte = sum_ff[7:0];
         5'd17: frame_byte = sum_ff[15:8];
         5'd18: frame_byte = sum_ff[23:16];
         5'd19: frame_byte = sum_ff[31:24];
         default: frame_byte = 8'd0;
      endcase
   end

   always_comb begin
      pos_in         = pos_ff;
      sum_in         = sum_ff;
      pop            = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = load || (rsp_valid_ff && rsp_stall);

      if (load) begin
         rsp_payload_in = '0;
         if (head_cmd.kind == fcr_pkg::CMD_VERDICT) begin
            rsp_payload_in.result_kind     = fcr_pkg::RESULT_VERDICT;
            rsp_payload_in.last            = 1'b1;
            rsp_payload_in.frame_valid     = head_cmd.frame_valid;
            rsp_payload_in.valid_total     = 32'(head_cmd.valid_total);
            rsp_payload_in.invalid_total   = 32'(head_cmd.invalid_total);
            rsp_payload_in.received_length = head_cmd.received_length;
            pop = 1'b1;
         end else begin
            rsp_payload_in.result_kind = fcr_pkg::RESULT_REPLY;
            rsp_payload_in.out_byte    = frame_byte;
            rsp_payload_in.last        = at_last;
            if (pos_ff < fcr_pkg::POS_SUM0) begin
               sum_in = fcr_pkg::sum_step(sum_ff, frame_byte);
            end else if (at_last) begin
               sum_in = fcr_pkg::SUM_SEED;
            end
            if (at_last) begin
               pos_in = '0;
               pop    = 1'b1;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= fcr_pkg::SUM_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[sv/frame_check_and_reply_engine.sv]
// Top level of the frame check and reply engine: front end, command queue and back end.
`default_nettype none

// The request channel (req_valid, req_stall, req_payload) carries bus events: a written
// byte, a write stop or a read request. A request is taken at a rising edge with
// req_valid high and req_stall low. Written bytes and unknown request codes are
// absorbed and never produce a result.
// A write stop produces one verdict; a read request produces the 20-byte reply frame,
// least significant byte first, with last set on its final byte. Both are turned into
// commands in the front end and held in a two-entry queue, so the front keeps taking
// requests while the back end is still sending a frame.
// Results reach the rsp_ channel through the queue and the registered output.
// The back end emits one result per cycle while rsp_stall is low; a single byte
// sequencer steps through each reply frame and also folds the checksum over bytes 0
// to 15 as they pass. req_stall rises only while the queue holds two commands.
// When the receiver raises rsp_stall, the output register holds its result unchanged
// and the sequencer pauses; back pressure then reaches req_stall through the queue.
// Reply fields are captured when the read request is accepted.
// The csr_ port writes node_role, session_nonce and trace_enable; it may be used only
// while the block is idle. Synchronous reset restores the registers (role 12), clears
// the counters with the prepared count at one, empties the queue and drops any result.
module frame_check_and_reply_engine (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire fcr_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output fcr_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_write_enable,
   input  wire logic [1:0]               csr_index,
   input  wire logic [31:0]              csr_write_data
);

   // Commands flow from the front end through the queue to the back end.
   fcr_pkg::cmd_type          push_cmd;
   fcr_pkg::cmd_type          head_cmd;
   fcr_pkg::queue_status_type queue_status;
   logic                      push;
   logic                      pop;

   // The front end classifies each request and updates the receive state.
   fcr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // The queue decouples request intake from result delivery.
   fcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   // The back end sequences verdicts and reply bytes into the output register.
   fcr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule

`default_nettype wire

[test/frame_check_and_reply_engine_test.sv]
// Self-checking testbench for the frame check and reply engine.
module frame_check_and_reply_engine_test;

   // Register index 3 decodes to nothing; a write to it must leave every register alone.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // The watchdog trips after this many cycles in which no request, result or
   // register write is accepted. The longest legal quiet stretch is a long stall
   // or gap plus the idle pause before a register write.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed after the last expected result before the block counts as idle.
   localparam int SETTLE_CYCLES  = 10;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_ITEMS   = 50;
   localparam int PHASE_ITEMS    = 25;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   fcr_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   fcr_pkg::rsp_payload_type rsp_payload;
   logic                     csr_write_enable = 1'b0;
   logic [1:0]               csr_index = '0;
   logic [31:0]              csr_write_data = '0;

   frame_check_and_reply_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the registers, kept in step with every write on the csr_ port.
   logic [6:0]  cfg_role  = fcr_pkg::NODE_ROLE_RESET;
   logic [31:0] cfg_nonce = '0;
   logic        cfg_trace = 1'b0;

   // Shadow copy of the receive state and the frame counters.
   logic [4:0]  rx_pos        = '0;
   logic [31:0] rx_sum        = fcr_pkg::SUM_SEED;
   logic        rx_header_ok  = 1'b1;
   logic [31:0] rx_stored_sum = '0;
   logic [7:0]  rx_len        = '0;
   logic [31:0] valid_cnt     = '0;
   logic [31:0] invalid_cnt   = '0;
   logic [31:0] prepared_cnt  = 32'd1;

   // Verdicts and reply bytes that the block still owes, oldest first.
   fcr_pkg::rsp_payload_type rsp_due_q[$];

   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   int          item_count = 0;
   int          burst_left = 0;
   logic [7:0]  frame_buf [0:19];

   initial begin
      forever #1 clock = ~clock;
   end

   // One step of the frame checksum: rotate left by five, then fold in the byte.
   function automatic logic [31:0] fold_byte(logic [31:0] acc, logic [7:0] b);
      return {acc[26:0], acc[31:27]} ^ {24'd0, b};
   endfunction

   // Gap lengths: mostly none, sometimes short, rarely a long pause.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Advances the shadow state by one accepted request and queues what it owes.
   // A written byte only feeds the check; a write stop owes a verdict; a read owes
   // the 20-byte reply frame built from the registers and counters as they stand now.
   function automatic void track_bus_request(fcr_pkg::req_payload_type r);
      fcr_pkg::rsp_payload_type o;
      logic                     ok;
      logic [7:0]               reply [0:19];
      logic [31:0]              s;
      case (r.req_type)
         fcr_pkg::REQ_BYTE: begin
            if (rx_pos < fcr_pkg::FRAME_BYTES) begin
               if (rx_pos == 0 && r.data_byte != fcr_pkg::MAGIC_LO) rx_header_ok = 1'b0;
               if (rx_pos == 1 && r.data_byte != fcr_pkg::MAGIC_HI) rx_header_ok = 1'b0;
               if (rx_pos == 2 && r.data_byte != fcr_pkg::EXPECTED_ROLE) begin
                  rx_header_ok = 1'b0;
               end
               if (rx_pos < fcr_pkg::SUM_BYTES) begin
                  rx_sum = fold_byte(rx_sum, r.data_byte);
               end else begin
                  rx_stored_sum[8*(rx_pos - 5'd16) +: 8] = r.data_byte;
               end
               rx_pos = rx_pos + 5'd1;
            end
            if (rx_len != 8'hFF) rx_len = rx_len + 8'd1;
         end
         fcr_pkg::REQ_STOP: begin
            ok = (rx_pos == fcr_pkg::FRAME_BYTES) && rx_header_ok && (rx_sum == rx_stored_sum);
            if (ok) valid_cnt = valid_cnt + 32'd1;
            else invalid_cnt = invalid_cnt + 32'd1;
            prepared_cnt = prepared_cnt + 32'd1;
            o = '0;
            o.result_kind     = fcr_pkg::RESULT_VERDICT;
            o.last            = 1'b1;
            o.frame_valid     = ok;
            o.valid_total     = valid_cnt;
            o.invalid_total   = invalid_cnt;
            o.received_length = rx_len;
            rsp_due_q.push_back(o);
            rx_pos        = '0;
            rx_sum        = fcr_pkg::SUM_SEED;
            rx_header_ok  = 1'b1;
            rx_stored_sum = '0;
            rx_len        = '0;
         end
         fcr_pkg::REQ_READ: begin
            reply[0] = fcr_pkg::MAGIC_LO;
            reply[1] = fcr_pkg::MAGIC_HI;
            reply[2] = {1'b0, cfg_role};
            reply[3] = {7'd0, cfg_trace};
            for (int i = 0; i < 4; i++) begin
               reply[4 + i]  = cfg_nonce[8*i +: 8];
               reply[8 + i]  = prepared_cnt[8*i +: 8];
               reply[12 + i] = valid_cnt[8*i +: 8];
            end
            s = fcr_pkg::SUM_SEED;
            for (int i = 0; i < fcr_pkg::SUM_BYTES; i++) s = fold_byte(s, reply[i]);
            for (int i = 0; i < 4; i++) reply[fcr_pkg::SUM_BYTES + i] = s[8*i +: 8];
            for (int i = 0; i < fcr_pkg::FRAME_BYTES; i++) begin
               o = '0;
               o.result_kind = fcr_pkg::RESULT_REPLY;
               o.out_byte    = reply[i];
               o.last        = (i == fcr_pkg::FRAME_BYTES - 1);
               rsp_due_q.push_back(o);
            end
         end
         default: begin
            // Unknown request codes are swallowed without a trace.
         end
      endcase
   endfunction

   task automatic note_mismatch(string what, fcr_pkg::rsp_payload_type want,
                                fcr_pkg::rsp_payload_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s: expected kind=%0d byte=%h last=%0d ok=%0d valid=%h invalid=%h len=%0d",
                  what, want.result_kind, want.out_byte, want.last, want.frame_valid,
                  want.valid_total, want.invalid_total, want.received_length);
         $display("%s:   actual kind=%0d byte=%h last=%0d ok=%0d valid=%h invalid=%h len=%0d",
                  what, got.result_kind, got.out_byte, got.last, got.frame_valid,
                  got.valid_total, got.invalid_total, got.received_length);
      end
   endtask

   // Everything is sampled at the rising edge, while the block's outputs still hold
   // the values they had before the edge. A result is checked before the request of
   // the same edge is tracked; a request can never cause a result in its own cycle.
   always @(posedge clock) begin : watch_channels
      fcr_pkg::rsp_payload_type want;
      logic                     moved;
      moved = csr_write_enable;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            moved = 1'b1;
            if (rsp_due_q.size() == 0) begin
               note_mismatch("result with nothing due", '0, rsp_payload);
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_payload.result_kind !== want.result_kind ||
                   rsp_payload.out_byte !== want.out_byte ||
                   rsp_payload.last !== want.last ||
                   rsp_payload.frame_valid !== want.frame_valid ||
                   rsp_payload.valid_total !== want.valid_total ||
                   rsp_payload.invalid_total !== want.invalid_total ||
                   rsp_payload.received_length !== want.received_length) begin
                  note_mismatch("result mismatch", want, rsp_payload);
               end
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            moved = 1'b1;
            track_bus_request(req_payload);
         end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
   end

   // Any stretch this long without progress means the block has hung.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   // Result-side back pressure: short runs of ready cycles broken by stalls of random
   // length, with an occasional long stretch that never stalls.
   initial begin
      int unsigned run;
      int unsigned hold;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) run = $urandom_range(30, 80);
         else run = $urandom_range(1, 8);
         repeat (run) @(negedge clock);
         hold = pick_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one request from a falling edge and returns at the falling edge after it
   // is taken. The valid is only lowered when a gap follows, so back-to-back requests
   // keep it high without a glitch.
   task automatic send_request(logic [1:0] kind, logic [7:0] data);
      int unsigned gap;
      logic        taken;
      req_payload <= '{req_type: kind, data_byte: data};
      req_valid   <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = (req_stall === 1'b0);
      end
      @(negedge clock);
      if (kind != fcr_pkg::REQ_NONE) item_count++;
      if (burst_left != 0) begin
         burst_left--;
         gap = 0;
      end else if ($urandom_range(0, 39) == 0) begin
         burst_left = $urandom_range(20, 60);
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stops offering requests and waits until every owed result has arrived and the
   // block has had time to absorb any trailing written bytes.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (rsp_due_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         fcr_pkg::CSR_NODE_ROLE:     cfg_role  = data[6:0];
         fcr_pkg::CSR_SESSION_NONCE: cfg_nonce = data;
         fcr_pkg::CSR_TRACE_ENABLE:  cfg_trace = data[0];
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic set_registers(logic [31:0] role, logic [31:0] nonce, logic [31:0] trace);
      write_csr(fcr_pkg::CSR_NODE_ROLE, role);
      write_csr(fcr_pkg::CSR_SESSION_NONCE, nonce);
      write_csr(fcr_pkg::CSR_TRACE_ENABLE, trace);
   endtask

   // Recomputes the checksum after the body of frame_buf has been edited.
   function automatic void fill_good_frame_checksum();
      logic [31:0] s;
      s = fcr_pkg::SUM_SEED;
      for (int i = 0; i < fcr_pkg::SUM_BYTES; i++) s = fold_byte(s, frame_buf[i]);
      for (int i = 0; i < 4; i++) frame_buf[fcr_pkg::SUM_BYTES + i] = s[8*i +: 8];
   endfunction

   // Builds a well-formed frame in frame_buf: magic, the expected role, random body and
   // the matching checksum in the last four bytes.
   function automatic void fill_good_frame();
      frame_buf[0] = fcr_pkg::MAGIC_LO;
      frame_buf[1] = fcr_pkg::MAGIC_HI;
      frame_buf[2] = fcr_pkg::EXPECTED_ROLE;
      for (int i = 3; i < fcr_pkg::SUM_BYTES; i++) frame_buf[i] = 8'($urandom_range(0, 255));
      fill_good_frame_checksum();
   endfunction

   // Writes the first n bytes of frame_buf, random filler past the twentieth. When mixed
   // is set, a read or an unknown request now and then slips in between bytes; neither
   // may disturb the write in progress.
   task automatic send_write(int unsigned n, bit mixed);
      for (int unsigned i = 0; i < n; i++) begin
         if (mixed && $urandom_range(0, 29) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
               send_request(fcr_pkg::REQ_READ, 8'($urandom_range(0, 255)));
            end else begin
               send_request(fcr_pkg::REQ_NONE, 8'($urandom_range(0, 255)));
            end
         end
         if (i < fcr_pkg::FRAME_BYTES) send_request(fcr_pkg::REQ_BYTE, frame_buf[i]);
         else send_request(fcr_pkg::REQ_BYTE, 8'($urandom_range(0, 255)));
      end
   endtask

   // Reset values, the empty write, a clean frame whose body holds both byte
   // extremes, and an unknown request code.
   task automatic test_directed();
      send_request(fcr_pkg::REQ_READ, 8'hFF);
      send_request(fcr_pkg::REQ_STOP, 8'h00);
      send_request(fcr_pkg::REQ_NONE, 8'hFF);
      fill_good_frame();
      frame_buf[3] = 8'h00;
      frame_buf[4] = 8'hFF;
      fill_good_frame_checksum();
      send_write(fcr_pkg::FRAME_BYTES, 1'b0);
      send_request(fcr_pkg::REQ_STOP, 8'hFF);
      send_request(fcr_pkg::REQ_READ, 8'h00);
   endtask

   // All-ones and all-zeros register settings. The data words carry stray upper bits
   // that the narrow registers must drop, and the spare index must change nothing.
   task automatic test_register_extremes();
      wait_idle();
      set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE, $urandom);
      send_request(fcr_pkg::REQ_READ, 8'h00);
      fill_good_frame();
      send_write(fcr_pkg::FRAME_BYTES, 1'b0);
      send_request(fcr_pkg::REQ_STOP, 8'h00);
      send_request(fcr_pkg::REQ_READ, 8'h00);
      wait_idle();
      set_registers(32'hFFFF_FF80, 32'h0000_0000, 32'hFFFF_FFFE);
      send_request(fcr_pkg::REQ_READ, 8'h00);
   endtask

   // A clean frame followed by enough filler that the length report saturates; the
   // filler must not spoil the verdict.
   task automatic test_length_saturation();
      fill_good_frame();
      send_write(260, 1'b0);
      send_request(fcr_pkg::REQ_STOP, 8'($urandom_range(0, 255)));
      send_request(fcr_pkg::REQ_READ, 8'($urandom_range(0, 255)));
   endtask

   // Well-formed frames with random bodies, a share of broken, short and long
   // writes, reads in between, and some raw noise. The registers change between
   // phases, the role sometimes to its extremes.
   task automatic test_random_traffic();
      int          start;
      int          phase_start;
      int unsigned pick;
      int unsigned spot;
      logic [31:0] role;
      start = item_count;
      while (item_count - start < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 3))
            0:       role = 32'h0000_007F;
            1:       role = 32'h0000_0000;
            default: role = $urandom;
         endcase
         set_registers(role, $urandom, $urandom);
         phase_start = item_count;
         while (item_count - phase_start < PHASE_ITEMS &&
                item_count - start < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            fill_good_frame();
            if (pick < 45) begin
               send_write(fcr_pkg::FRAME_BYTES, 1'b1);
               send_request(fcr_pkg::REQ_STOP, 8'($urandom_range(0, 255)));
            end else if (pick < 60) begin
               // One flaw per frame: a magic byte, the role, the stored checksum,
               // or a body byte that no longer matches the stored checksum.
               case ($urandom_range(0, 4))
                  0: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(1, 255));
                  1: frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(1, 255));
                  2: frame_buf[2] = frame_buf[2] ^ 8'($urandom_range(1, 255));
                  3: begin
                     spot = fcr_pkg::SUM_BYTES + $urandom_range(0, 3);
                     frame_buf[spot] = frame_buf[spot] ^ (8'd1 << $urandom_range(0, 7));
                  end
                  default: begin
                     spot = $urandom_range(3, fcr_pkg::SUM_BYTES - 1);
                     frame_buf[spot] = frame_buf[spot] ^ 8'($urandom_range(1, 255));
                  end
               endcase
               send_write(fcr_pkg::FRAME_BYTES, 1'b1);
               send_request(fcr_pkg::REQ_STOP, 8'($urandom_range(0, 255)));
            end else if (pick < 70) begin
               send_write($urandom_range(0, fcr_pkg::FRAME_BYTES - 1), 1'b1);
               send_request(fcr_pkg::REQ_STOP, 8'($urandom_range(0, 255)));
            end else if (pick < 78) begin
               send_write($urandom_range(fcr_pkg::FRAME_BYTES + 1, 45), 1'b1);
               send_request(fcr_pkg::REQ_STOP, 8'($urandom_range(0, 255)));
            end else if (pick < 88) begin
               send_request(fcr_pkg::REQ_READ, 8'($urandom_range(0, 255)));
            end else if (pick < 93) begin
               send_request(fcr_pkg::REQ_STOP, 8'($urandom_range(0, 255)));
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
               end
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_length_saturation();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
